// File: sv/wlpr_pkg.sv
// Shared widths, status codes and register indexes of the wear-leveling page remapper.
package wlpr_pkg;

  localparam int unsigned PAGE_W   = 36;
  localparam int unsigned WEAR_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PIU_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WEAR_W-1:0] WEAR_MAX = {WEAR_W{1'b1}};
  localparam logic [PIU_W-1:0]  PIU_RESET = 9'd256;

  localparam logic [STATUS_W-1:0] STATUS_STAY = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SWAP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OOR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_PAGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 2'd1;

  // Write enables of the three tables.
  typedef struct packed {
    logic wear;
    logic owner;
    logic fop;
  } wlpr_we_t;

  // Control of the shared least-wear compare unit.
  typedef struct packed {
    logic valid;
    logic first;
  } wlpr_scan_ctl_t;

  function automatic logic [WEAR_W-1:0] sat_inc(input logic [WEAR_W-1:0] v);
    sat_inc = (v == WEAR_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// File: sv/wlpr_tables.sv
// Wear, owner-of-frame and frame-of-page tables with registered reads.
module wlpr_tables
  import wlpr_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 256,
  parameter int unsigned IW = 8
) (
  input  logic              clk_i,
  input  wlpr_we_t          we_i,
  input  logic [IW-1:0]     wear_waddr_i,
  input  logic [WEAR_W-1:0] wear_wdata_i,
  input  logic [IW-1:0]     wear_raddr_i,
  output logic [WEAR_W-1:0] wear_rdata_o,
  input  logic [IW-1:0]     owner_waddr_i,
  input  logic [IW-1:0]     owner_wdata_i,
  input  logic [IW-1:0]     owner_raddr_i,
  output logic [IW-1:0]     owner_rdata_o,
  input  logic [IW-1:0]     fop_waddr_i,
  input  logic [IW-1:0]     fop_wdata_i,
  input  logic [IW-1:0]     fop_raddr_i,
  output logic [IW-1:0]     fop_rdata_o
);

  logic [WEAR_W-1:0] wear_mem  [NUM_PAGES];
  logic [IW-1:0]     owner_mem [NUM_PAGES];
  logic [IW-1:0]     fop_mem   [NUM_PAGES];

  always_ff @(posedge clk_i) begin
    if (we_i.wear) begin
      wear_mem[wear_waddr_i] <= wear_wdata_i;
    end
    wear_rdata_o <= wear_mem[wear_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.owner) begin
      owner_mem[owner_waddr_i] <= owner_wdata_i;
    end
    owner_rdata_o <= owner_mem[owner_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.fop) begin
      fop_mem[fop_waddr_i] <= fop_wdata_i;
    end
    fop_rdata_o <= fop_mem[fop_raddr_i];
  end

endmodule

// File: sv/wlpr_scan.sv
// Shared compare unit that tracks the least-worn frame during a scan.
module wlpr_scan
  import wlpr_pkg::*;
#(
  parameter int unsigned IW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wlpr_scan_ctl_t    ctl_i,
  input  logic [IW-1:0]     idx_i,
  input  logic [WEAR_W-1:0] wear_i,
  output logic [WEAR_W-1:0] best_wear_o,
  output logic [IW-1:0]     best_idx_o
);

  logic [WEAR_W-1:0] best_wear_q, best_wear_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;

  // Strict less-than keeps the lowest index on a tie.
  always_comb begin
    best_wear_d = best_wear_q;
    best_idx_d  = best_idx_q;
    if (ctl_i.valid && (ctl_i.first || (wear_i < best_wear_q))) begin
      best_wear_d = wear_i;
      best_idx_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_wear_q <= '0;
      best_idx_q  <= '0;
    end else begin
      best_wear_q <= best_wear_d;
      best_idx_q  <= best_idx_d;
    end
  end

  assign best_wear_o = best_wear_q;
  assign best_idx_o  = best_idx_q;

endmodule

// File: sv/wear_leveling_page_remapper.sv
// Top level of the wear-leveling page remapper: sequencer, config and result register.
//
// Input channel (in_valid_i/in_ready_o, page_number_i): one transaction names a
// virtual page that crossed its write threshold. Output channel
// (out_valid_o/out_ready_i): one transaction per input with status, frames,
// displaced page, wear after the step and the running swap total.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 base_page, 1 pages_in_use); other indexes are dropped. Write only while idle.
// Scan: an in-range page runs a linear least-wear scan over the first n entries
// of the wear table, n being the clamped pages_in_use (one read port, one
// compare a cycle); a page that swaps also passes S_WR2 before the result
// register loads. An out-of-range page skips the scan.
// One page is worked on at a time; in_ready_o is high only when the sequencer
// is idle, which it is again from the cycle after the result register loads.
// Reset: a clearing pass over all NUM_PAGES entries writes identity maps and zero
// wear; no input is taken during it, config writes are taken as ever.
// Stall: a finished result waits in the output register; the next page is
// accepted meanwhile, and its result holds in the sequencer until the
// output register is free.
module wear_leveling_page_remapper
  import wlpr_pkg::*;
#(
  parameter int unsigned NUM_PAGES = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [PAGE_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PAGE_W-1:0]    page_number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [PAGE_W-1:0]    dest_frame_o,
  output logic [PAGE_W-1:0]    source_frame_o,
  output logic [PAGE_W-1:0]    displaced_page_o,
  output logic [WEAR_W-1:0]    wear_after_o,
  output logic [WEAR_W-1:0]    rebalance_total_o
);

  localparam int unsigned IW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int unsigned CW = $clog2(NUM_PAGES + 1);
  localparam int unsigned NW = (CW > PIU_W) ? CW : PIU_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RDMAP = 3'd4;
  localparam logic [2:0] S_DEC   = 3'd5;
  localparam logic [2:0] S_WR2   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;

  // Configuration registers.
  logic [PAGE_W-1:0] base_q;
  logic [PIU_W-1:0]  piu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      piu_q  <= PIU_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BASE_PAGE:    base_q <= cfg_data_i;
        CFG_PAGES_IN_USE: piu_q  <= cfg_data_i[PIU_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp pages_in_use to 1..NUM_PAGES.
  logic [NW-1:0] piu_ext;
  logic [CW-1:0] n_eff;
  always_comb begin
    piu_ext = NW'(piu_q);
    if (piu_q == '0) begin
      n_eff = CW'(1);
    end else if (piu_ext > NW'(NUM_PAGES)) begin
      n_eff = CW'(NUM_PAGES);
    end else begin
      n_eff = piu_ext[CW-1:0];
    end
  end

  // Sequencer state.
  logic [IW-1:0]     clr_q, clr_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [IW-1:0]     pi_q, pi_d;
  logic [CW-1:0]     rd_cnt_q, rd_cnt_d;
  logic              cmp_v_q, cmp_v_d;
  logic [IW-1:0]     cmp_idx_q, cmp_idx_d;
  logic [IW-1:0]     src_q, src_d;
  logic [IW-1:0]     other_q, other_d;
  logic [WEAR_W-1:0] swap_q, swap_d;
  logic              out_valid_q, out_valid_d;

  // Pending result, moved to the output register in S_DONE.
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [PAGE_W-1:0]   res_dest_q, res_dest_d;
  logic [PAGE_W-1:0]   res_src_q, res_src_d;
  logic [PAGE_W-1:0]   res_disp_q, res_disp_d;
  logic [WEAR_W-1:0]   res_wear_q, res_wear_d;
  logic [WEAR_W-1:0]   res_total_q, res_total_d;
  logic                load_out;

  // Table and scan unit wiring.
  wlpr_we_t          we;
  logic [IW-1:0]     wear_waddr, wear_raddr, owner_waddr, owner_wdata, owner_raddr;
  logic [IW-1:0]     fop_waddr, fop_wdata, fop_raddr, owner_rdata, fop_rdata;
  logic [WEAR_W-1:0] wear_wdata, wear_rdata, best_wear, wear_new;
  logic [IW-1:0]     best_idx;
  wlpr_scan_ctl_t    scan_ctl;

  logic [PAGE_W:0]   diff;
  logic              in_range;

  assign diff     = {1'b0, page_q} - {1'b0, base_q};
  assign in_range = !diff[PAGE_W] && (diff[PAGE_W-1:0] < PAGE_W'(n_eff));
  assign wear_new = sat_inc(best_wear);

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    page_d       = page_q;
    pi_d         = pi_q;
    rd_cnt_d     = rd_cnt_q;
    cmp_v_d      = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    src_d        = src_q;
    other_d      = other_q;
    swap_d       = swap_q;
    res_status_d = res_status_q;
    res_dest_d   = res_dest_q;
    res_src_d    = res_src_q;
    res_disp_d   = res_disp_q;
    res_wear_d   = res_wear_q;
    res_total_d  = res_total_q;
    load_out     = 1'b0;

    we          = '0;
    wear_waddr  = best_idx;
    wear_wdata  = wear_new;
    wear_raddr  = rd_cnt_q[IW-1:0];
    owner_waddr = best_idx;
    owner_wdata = pi_q;
    owner_raddr = best_idx;
    fop_waddr   = pi_q;
    fop_wdata   = best_idx;
    fop_raddr   = pi_q;

    scan_ctl.valid = cmp_v_q;
    scan_ctl.first = (cmp_idx_q == '0);

    case (state_q)
      S_CLEAR: begin
        we.wear     = 1'b1;
        we.owner    = 1'b1;
        we.fop      = 1'b1;
        wear_waddr  = clr_q;
        wear_wdata  = '0;
        owner_waddr = clr_q;
        owner_wdata = clr_q;
        fop_waddr   = clr_q;
        fop_wdata   = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == IW'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          page_d  = page_number_i;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        pi_d     = diff[IW-1:0];
        rd_cnt_d = '0;
        if (!in_range) begin
          res_status_d = STATUS_OOR;
          res_dest_d   = '0;
          res_src_d    = '0;
          res_disp_d   = '0;
          res_wear_d   = '0;
          res_total_d  = swap_q;
          state_d      = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Issue one wear read a cycle; its compare follows in the next cycle.
        if (rd_cnt_q < n_eff) begin
          cmp_v_d   = 1'b1;
          cmp_idx_d = rd_cnt_q[IW-1:0];
          rd_cnt_d  = rd_cnt_q + 1'b1;
        end else begin
          state_d = S_RDMAP;
        end
      end
      S_RDMAP: begin
        state_d = S_DEC;
      end
      S_DEC: begin
        we.wear     = 1'b1;
        res_dest_d  = base_q + PAGE_W'(best_idx);
        res_wear_d  = wear_new;
        if (owner_rdata == pi_q) begin
          res_status_d = STATUS_STAY;
          res_src_d    = base_q + PAGE_W'(best_idx);
          res_disp_d   = page_q;
          res_total_d  = swap_q;
          state_d      = S_DONE;
        end else begin
          we.owner     = 1'b1;
          we.fop       = 1'b1;
          src_d        = fop_rdata;
          other_d      = owner_rdata;
          swap_d       = sat_inc(swap_q);
          res_status_d = STATUS_SWAP;
          res_src_d    = base_q + PAGE_W'(fop_rdata);
          res_disp_d   = base_q + PAGE_W'(owner_rdata);
          res_total_d  = sat_inc(swap_q);
          state_d      = S_WR2;
        end
      end
      S_WR2: begin
        // Move the displaced page into the source frame.
        we.owner    = 1'b1;
        we.fop      = 1'b1;
        owner_waddr = src_q;
        owner_wdata = other_q;
        fop_waddr   = other_q;
        fop_wdata   = src_q;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rd_cnt_q    <= '0;
      cmp_v_q     <= 1'b0;
      swap_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_cnt_q    <= rd_cnt_d;
      cmp_v_q     <= cmp_v_d;
      swap_q      <= swap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q       <= page_d;
    pi_q         <= pi_d;
    cmp_idx_q    <= cmp_idx_d;
    src_q        <= src_d;
    other_q      <= other_d;
    res_status_q <= res_status_d;
    res_dest_q   <= res_dest_d;
    res_src_q    <= res_src_d;
    res_disp_q   <= res_disp_d;
    res_wear_q   <= res_wear_d;
    res_total_q  <= res_total_d;
    if (load_out) begin
      status_o          <= res_status_q;
      dest_frame_o      <= res_dest_q;
      source_frame_o    <= res_src_q;
      displaced_page_o  <= res_disp_q;
      wear_after_o      <= res_wear_q;
      rebalance_total_o <= res_total_q;
    end
  end

  assign out_valid_o = out_valid_q;

  wlpr_tables #(
    .NUM_PAGES(NUM_PAGES),
    .IW       (IW)
  ) u_tables (
    .clk_i        (clk_i),
    .we_i         (we),
    .wear_waddr_i (wear_waddr),
    .wear_wdata_i (wear_wdata),
    .wear_raddr_i (wear_raddr),
    .wear_rdata_o (wear_rdata),
    .owner_waddr_i(owner_waddr),
    .owner_wdata_i(owner_wdata),
    .owner_raddr_i(owner_raddr),
    .owner_rdata_o(owner_rdata),
    .fop_waddr_i  (fop_waddr),
    .fop_wdata_i  (fop_wdata),
    .fop_raddr_i  (fop_raddr),
    .fop_rdata_o  (fop_rdata)
  );

  wlpr_scan #(
    .IW(IW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .idx_i      (cmp_idx_q),
    .wear_i     (wear_rdata),
    .best_wear_o(best_wear),
    .best_idx_o (best_idx)
  );

endmodule

// File: tb/wear_leveling_page_remapper_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the wear-leveling page remapper: stimulus, predictor and checks.
module wear_leveling_page_remapper_test;
  import wlpr_pkg::*;

  localparam int unsigned NUM_PAGES       = 256;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned RAND_PHASES     = 35;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  // Phase in which the receiver holds off long enough for the block to back up.
  localparam int unsigned HOLD_PHASE      = 3;
  localparam int unsigned HOLD_CYCLES     = 400;
  // From this phase on neither side idles.
  localparam int unsigned QUIET_PHASE     = 31;
  // Longest scan with margin; used for the settle time at the end.
  localparam int unsigned SETTLE_CYCLES   = 300;
  // Slowest legal run: every page at the full scan plus both sides idling, times four.
  localparam int unsigned LIMIT_CYCLES    = 2_000_000;
  localparam int unsigned PRINT_CAP       = 100;

  localparam logic [PAGE_W-1:0]    PAGE_MAX     = '1;
  // Register indexes past the end of the map; the block drops writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   dest_frame;
    logic [PAGE_W-1:0]   source_frame;
    logic [PAGE_W-1:0]   displaced_page;
    logic [WEAR_W-1:0]   wear_after;
    logic [WEAR_W-1:0]   rebalance_total;
  } remap_t;

  // Block ports; every input starts at a known value.
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = CFG_BASE_PAGE;
  logic [PAGE_W-1:0]    cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [PAGE_W-1:0]    page_number_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [PAGE_W-1:0]    dest_frame_o;
  logic [PAGE_W-1:0]    source_frame_o;
  logic [PAGE_W-1:0]    displaced_page_o;
  logic [WEAR_W-1:0]    wear_after_o;
  logic [WEAR_W-1:0]    rebalance_total_o;

  // Predictor copy of the remap tables and the registers.
  logic [IDX_W-1:0]     frame_holder [NUM_PAGES];  // page index held by each frame
  logic [IDX_W-1:0]     page_home    [NUM_PAGES];  // frame index holding each page
  logic [WEAR_W-1:0]    frame_wear   [NUM_PAGES];
  logic [WEAR_W-1:0]    swaps_done;
  logic [PAGE_W-1:0]    base_cfg;
  logic [PIU_W-1:0]     piu_cfg;

  logic [PAGE_W-1:0]    queued_pages[$];     // pages not yet offered to the block
  remap_t               expected_remaps[$];  // predictions waiting for their result

  bit                   idle_on     = 1'b1;
  bit                   stall_out   = 1'b0;
  int unsigned          send_gap    = 0;
  int unsigned          recv_gap    = 0;
  int unsigned          mismatch_count = 0;
  int unsigned          cycle_count = 0;

  wear_leveling_page_remapper #(
    .NUM_PAGES(NUM_PAGES)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .page_number_i    (page_number_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .dest_frame_o     (dest_frame_o),
    .source_frame_o   (source_frame_o),
    .displaced_page_o (displaced_page_o),
    .wear_after_o     (wear_after_o),
    .rebalance_total_o(rebalance_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp pages_in_use: zero counts as one, anything past the table as the full table.
  function automatic int unsigned active_frames();
    if (piu_cfg == '0) return 1;
    if (piu_cfg > NUM_PAGES) return NUM_PAGES;
    return int'(piu_cfg);
  endfunction

  // Advance the predicted tables by one hot page and return the result it should give.
  function automatic remap_t predict_remap(input logic [PAGE_W-1:0] page);
    remap_t          r;
    int unsigned     n;
    int unsigned     pick;
    int unsigned     idx;
    int unsigned     src;
    int unsigned     other;
    logic [PAGE_W-1:0] offs;
    n    = active_frames();
    offs = page - base_cfg;
    r    = '0;
    r.rebalance_total = swaps_done;
    // Out of range: report zeros and the swap total, touch nothing.
    if (page < base_cfg || offs >= n) begin
      r.status = STATUS_OOR;
      return r;
    end
    idx = int'(offs);
    // Least-worn frame in the search set; a tie keeps the lower index.
    pick = 0;
    for (int unsigned f = 1; f < n; f++) begin
      if (frame_wear[f] < frame_wear[pick]) pick = f;
    end
    if (frame_wear[pick] != WEAR_MAX) frame_wear[pick] = frame_wear[pick] + 1'b1;
    r.dest_frame = base_cfg + PAGE_W'(pick);
    r.wear_after = frame_wear[pick];
    if (frame_holder[pick] == IDX_W'(idx)) begin
      // Page already sits in the least-worn frame: wear rises, no swap.
      r.status         = STATUS_STAY;
      r.source_frame   = r.dest_frame;
      r.displaced_page = page;
      return r;
    end
    // Swap the hot page with the page in the picked frame; the page may come from
    // a frame outside the search set after pages_in_use shrank.
    src   = page_home[idx];
    other = frame_holder[pick];
    page_home[idx]     = IDX_W'(pick);
    page_home[other]   = IDX_W'(src);
    frame_holder[pick] = IDX_W'(idx);
    frame_holder[src]  = IDX_W'(other);
    if (swaps_done != WEAR_MAX) swaps_done = swaps_done + 1'b1;
    r.status          = STATUS_SWAP;
    r.source_frame    = base_cfg + PAGE_W'(src);
    r.displaced_page  = base_cfg + PAGE_W'(other);
    r.rebalance_total = swaps_done;
    return r;
  endfunction

  task automatic note_failure(input string msg);
    if (mismatch_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [PAGE_W-1:0] got,
                             input logic [PAGE_W-1:0] want);
    if (got !== want) note_failure($sformatf("%s got %h want %h", name, got, want));
  endtask

  // Write one register and mirror it into the predictor; only call while idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAGE_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_BASE_PAGE:    base_cfg = data;
      CFG_PAGES_IN_USE: piu_cfg  = data[PIU_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Return once every queued page is accepted and every result has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_pages.size() != 0 || in_valid_i || expected_remaps.size() != 0);
  endtask

  // Sender: offer queued pages, hold each until its transaction completes, and
  // drop valid for random bursts while idling is on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) expected_remaps.push_back(predict_remap(page_number_i));
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (queued_pages.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i    <= 1'b1;
          page_number_i <= queued_pages.pop_front();
        end
      end
    end
  end

  // Receiver: check each result transaction against the oldest prediction, then
  // pick ready for the next cycle (long hold, short stall burst or ready).
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_remaps.size() == 0) begin
          note_failure("result with no prediction waiting");
        end else begin
          remap_t want;
          want = expected_remaps.pop_front();
          check_field("status", PAGE_W'(status_o), PAGE_W'(want.status));
          check_field("dest_frame", dest_frame_o, want.dest_frame);
          check_field("source_frame", source_frame_o, want.source_frame);
          check_field("displaced_page", displaced_page_o, want.displaced_page);
          check_field("wear_after", PAGE_W'(wear_after_o), PAGE_W'(want.wear_after));
          check_field("rebalance_total", PAGE_W'(rebalance_total_o),
                      PAGE_W'(want.rebalance_total));
        end
      end
      if (stall_out) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        recv_gap = $urandom_range(0, 3);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0]       r64;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] new_base;
    logic [PAGE_W-1:0] piu_data;
    int unsigned       n;
    int unsigned       sel;

    // Predictor starts from the reset state: identity maps, zero wear.
    for (int i = 0; i < NUM_PAGES; i++) begin
      frame_holder[i] = IDX_W'(i);
      page_home[i]    = IDX_W'(i);
      frame_wear[i]   = '0;
    end
    swaps_done = '0;
    base_cfg   = '0;
    piu_cfg    = PIU_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset registers: stay on first touch, then swaps, both range edges.
    queued_pages.push_back(36'd0);
    queued_pages.push_back(36'd0);
    queued_pages.push_back(36'd255);
    queued_pages.push_back(36'd256);
    queued_pages.push_back(PAGE_MAX);
    queued_pages.push_back(36'd1);
    queued_pages.push_back(36'd128);
    wait_drained();

    // Spare indexes must be dropped; oversize pages_in_use clamps to the table;
    // base near the top makes frame numbers wrap.
    write_reg(CFG_SPARE_LO, PAGE_MAX);
    write_reg(CFG_SPARE_HI, 36'h0_0000_0001);
    write_reg(CFG_PAGES_IN_USE, 36'h1FF);
    write_reg(CFG_BASE_PAGE, PAGE_MAX - 36'd3);
    queued_pages.push_back(PAGE_MAX - 36'd3);
    queued_pages.push_back(PAGE_MAX);
    queued_pages.push_back(PAGE_MAX - 36'd4);
    queued_pages.push_back(36'd0);
    queued_pages.push_back(PAGE_MAX - 36'd1);
    wait_drained();

    // Upper data bits above the register width are ignored: this sets three pages.
    write_reg(CFG_PAGES_IN_USE, 36'h0_0000_1003);
    write_reg(CFG_BASE_PAGE, 36'h8_0000_0000);
    queued_pages.push_back(36'h8_0000_0000);
    queued_pages.push_back(36'h8_0000_0002);
    queued_pages.push_back(36'h8_0000_0003);
    queued_pages.push_back(36'h8_0000_0001);
    queued_pages.push_back(36'h8_0000_0000);
    queued_pages.push_back(36'h7_FFFF_FFFF);
    wait_drained();

    // Zero pages_in_use counts as one: only frame 0 is searched.
    write_reg(CFG_PAGES_IN_USE, 36'd0);
    write_reg(CFG_BASE_PAGE, 36'h0_0000_1000);
    queued_pages.push_back(36'h0_0000_1000);
    queued_pages.push_back(36'h0_0000_1000);
    queued_pages.push_back(36'h0_0000_1001);
    queued_pages.push_back(36'h0_0000_0FFF);
    wait_drained();

    // Random phases: mostly small search sets so the scan stays short, a few full ones.
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      sel = $urandom_range(0, 19);
      if (ph == HOLD_PHASE)  piu_data = 36'd4;
      else if (sel == 0)     piu_data = 36'd0;
      else if (sel == 1)     piu_data = PAGE_W'($urandom_range(257, 511));
      else if (sel == 2)     piu_data = 36'd256;
      else if (sel == 3)     piu_data = PAGE_W'($urandom_range(17, 255));
      else                   piu_data = PAGE_W'($urandom_range(1, 16));
      r64 = {$urandom(), $urandom()};
      if ($urandom_range(0, 7) == 0) piu_data[PAGE_W-1:PIU_W] = r64[PAGE_W-1:PIU_W];
      sel = $urandom_range(0, 9);
      r64 = {$urandom(), $urandom()};
      if (sel == 0)                 new_base = '0;
      else if (sel == 1)            new_base = PAGE_MAX - PAGE_W'($urandom_range(0, 300));
      else if (sel == 2 || sel == 3) new_base = base_cfg;
      else                          new_base = r64[PAGE_W-1:0];
      if ($urandom_range(0, 7) == 0) begin
        r64 = {$urandom(), $urandom()};
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_LO : CFG_SPARE_HI, r64[PAGE_W-1:0]);
      end
      write_reg(CFG_PAGES_IN_USE, piu_data);
      write_reg(CFG_BASE_PAGE, new_base);
      n = active_frames();
      if (ph >= QUIET_PHASE) idle_on = 1'b0;

      // Mostly pages inside the window; the rest just outside it or anywhere.
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        sel = $urandom_range(0, 19);
        r64 = {$urandom(), $urandom()};
        if (sel == 0)      page = base_cfg - 36'd1 - PAGE_W'($urandom_range(0, 3));
        else if (sel == 1) page = base_cfg + PAGE_W'(n) + PAGE_W'($urandom_range(0, 3));
        else if (sel == 2) page = r64[PAGE_W-1:0];
        else               page = base_cfg + PAGE_W'($urandom_range(0, n - 1));
        queued_pages.push_back(page);
      end

      // Hold the receiver off while pages keep coming so the block backs up.
      if (ph == HOLD_PHASE) begin
        stall_out = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        stall_out = 1'b0;
      end
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
